### design/rru_pkg.sv
`timescale 1ns / 1ps

package rru_pkg;

  // Default operand width and fixed result width
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_WIDTH         = 32;
  localparam int MODE_WIDTH        = 2;

  // Operation codes
  localparam logic [MODE_WIDTH-1:0] MODE_REDUCE = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_PLUS   = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_MINUS  = 2'd2;
  localparam logic [MODE_WIDTH-1:0] MODE_MUL    = 2'd3;

  // Status of the shared subtract/compare unit
  typedef struct packed {
    logic borrow;
    logic zero;
  } sub_flags_t;

endpackage

### design/rational_reduce_unit.sv
`timescale 1ns / 1ps

// Rational reduce unit. Pulse start with a fraction pair and an operation
// (reduce A, A plus one, A minus one, A times B) while busy is low; the item
// is taken at that edge and busy stays high until the result is out. The
// result appears for exactly one cycle with out_valid high and must be
// captured then: there is no way to hold it. Operands are OPERAND_WIDTH-bit
// two's complement. A zero denominator on an entering fraction is replaced
// by one and reported on out_zero_den; a zero numerator in A is taken as
// 0/1 before the operation. Signs of numerator and denominator are kept as
// computed (the denominator is not forced positive), and results are
// truncated to 32 bits. An item passes through a capture step, the raw
// numerator and then the raw denominator formed on the shared multiplier,
// a step to take signs and magnitudes, a binary GCD of data-dependent
// length, then two restoring divisions, plus a step to drive the result.
// The GCD loop and the bit-serial divider share one subtractor.
// When the raw numerator is zero the GCD and divisions are skipped.
module rational_reduce_unit #(
  parameter int OPERAND_WIDTH = rru_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rru_pkg::MODE_WIDTH-1:0]    in_mode,
  input  logic signed [OPERAND_WIDTH-1:0]   in_num_a,
  input  logic signed [OPERAND_WIDTH-1:0]   in_den_a,
  input  logic signed [OPERAND_WIDTH-1:0]   in_num_b,
  input  logic signed [OPERAND_WIDTH-1:0]   in_den_b,
  output logic                              out_valid,
  output logic signed [rru_pkg::RES_WIDTH-1:0] out_res_num,
  output logic signed [rru_pkg::RES_WIDTH-1:0] out_res_den,
  output logic                              out_zero_den
);

  localparam int W  = OPERAND_WIDTH;
  localparam int SW = 2 * W;      // signed raw result
  localparam int MW = 2 * W - 1;  // magnitude of raw result
  localparam int RW = rru_pkg::RES_WIDTH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREPN = 3'd1;
  localparam logic [2:0] S_PREPD = 3'd2;
  localparam logic [2:0] S_MAG   = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Captured operands (zero denominators already replaced by one)
  logic [rru_pkg::MODE_WIDTH-1:0] mode_r, mode_nxt;
  logic signed [W-1:0] na_r, na_nxt;
  logic signed [W-1:0] da_r, da_nxt;
  logic signed [W-1:0] nb_r, nb_nxt;
  logic signed [W-1:0] db_r, db_nxt;
  logic                zflag_r, zflag_nxt;

  // Raw fraction before reduction
  logic signed [SW-1:0] raw_n_r, raw_n_nxt;
  logic signed [SW-1:0] raw_d_r, raw_d_nxt;
  logic                 n_neg_r, n_neg_nxt;
  logic                 d_neg_r, d_neg_nxt;

  logic signed [RW-1:0] res_num_r, res_num_nxt;
  logic signed [RW-1:0] res_den_r, res_den_nxt;

  logic                 accept;
  logic                 a_zero;
  logic signed [W-1:0]  mul_x;
  logic signed [W-1:0]  mul_y;
  logic signed [SW-1:0] mul_p;
  logic [SW-1:0]        n_abs;
  logic [SW-1:0]        d_abs;
  logic                 rd_start;
  logic                 rd_done;
  logic [MW-1:0]        rd_q_num;
  logic [MW-1:0]        rd_q_den;
  logic signed [SW-1:0] q_num_s;
  logic signed [SW-1:0] q_den_s;
  logic signed [SW-1:0] fin_num;
  logic signed [SW-1:0] fin_den;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign a_zero = (na_r == '0);

  // One multiplier, numerator product first, denominator product next
  assign mul_x = (state_r == S_PREPN) ? na_r : da_r;
  assign mul_y = (state_r == S_PREPN) ? nb_r : db_r;
  assign mul_p = SW'(mul_x) * SW'(mul_y);

  assign n_abs = raw_n_r[SW-1] ? SW'(-raw_n_r) : SW'(raw_n_r);
  assign d_abs = raw_d_r[SW-1] ? SW'(-raw_d_r) : SW'(raw_d_r);

  assign rd_start = (state_r == S_MAG) && (raw_n_r != '0);

  rru_reduce #(.MW(MW)) u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rd_start),
    .num_mag (n_abs[MW-1:0]),
    .den_mag (d_abs[MW-1:0]),
    .done    (rd_done),
    .q_num   (rd_q_num),
    .q_den   (rd_q_den)
  );

  // Reapply the signs to the reduced magnitudes
  assign q_num_s = $signed({1'b0, rd_q_num});
  assign q_den_s = $signed({1'b0, rd_q_den});
  assign fin_num = n_neg_r ? -q_num_s : q_num_s;
  assign fin_den = d_neg_r ? -q_den_s : q_den_s;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    mode_nxt      = mode_r;
    na_nxt        = na_r;
    da_nxt        = da_r;
    nb_nxt        = nb_r;
    db_nxt        = db_r;
    zflag_nxt     = zflag_r;
    raw_n_nxt     = raw_n_r;
    raw_d_nxt     = raw_d_r;
    n_neg_nxt     = n_neg_r;
    d_neg_nxt     = d_neg_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Hold the transfer; replace zero denominators and flag them
          mode_nxt  = in_mode;
          na_nxt    = in_num_a;
          da_nxt    = (in_den_a == '0) ? W'(1) : in_den_a;
          nb_nxt    = in_num_b;
          db_nxt    = (in_den_b == '0) ? W'(1) : in_den_b;
          zflag_nxt = (in_den_a == '0) ||
                      ((in_mode == rru_pkg::MODE_MUL) && (in_den_b == '0));
          state_nxt = S_PREPN;
        end
      end
      S_PREPN: begin
        // A zero numerator in A reduces to 0/1 before the operation
        if (a_zero) begin
          case (mode_r)
            rru_pkg::MODE_PLUS:  raw_n_nxt = SW'(1);
            rru_pkg::MODE_MINUS: raw_n_nxt = -SW'(1);
            default:             raw_n_nxt = '0;
          endcase
        end else begin
          case (mode_r)
            rru_pkg::MODE_PLUS:  raw_n_nxt = SW'(na_r) + SW'(da_r);
            rru_pkg::MODE_MINUS: raw_n_nxt = SW'(na_r) - SW'(da_r);
            rru_pkg::MODE_MUL:   raw_n_nxt = mul_p;
            default:             raw_n_nxt = SW'(na_r);
          endcase
        end
        state_nxt = S_PREPD;
      end
      S_PREPD: begin
        if (a_zero) begin
          raw_d_nxt = SW'(1);
        end else if (mode_r == rru_pkg::MODE_MUL) begin
          raw_d_nxt = mul_p;
        end else begin
          raw_d_nxt = SW'(da_r);
        end
        state_nxt = S_MAG;
      end
      S_MAG: begin
        n_neg_nxt = raw_n_r[SW-1];
        d_neg_nxt = raw_d_r[SW-1];
        if (raw_n_r == '0) begin
          // Zero numerator: drive 0/1 and skip the GCD
          res_num_nxt   = '0;
          res_den_nxt   = RW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (rd_done) begin
          res_num_nxt   = RW'(fin_num);
          res_den_nxt   = RW'(fin_den);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    na_r      <= na_nxt;
    da_r      <= da_nxt;
    nb_r      <= nb_nxt;
    db_r      <= db_nxt;
    zflag_r   <= zflag_nxt;
    raw_n_r   <= raw_n_nxt;
    raw_d_r   <= raw_d_nxt;
    n_neg_r   <= n_neg_nxt;
    d_neg_r   <= d_neg_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_res_num  = res_num_r;
  assign out_res_den  = res_den_r;
  assign out_zero_den = zflag_r;

  // A transfer in always makes the unit busy on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  // One result strobe per item; this checks that it is never back to back
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe lasted more than one cycle");

  // The reduced denominator can never be zero
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_done |-> (rd_q_den != '0))
    else $error("reduction produced a zero denominator");

  // The reducer only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_done |-> (state_r == S_WAIT))
    else $error("reducer finished outside the wait state");

endmodule

### design/rru_sub.sv
`timescale 1ns / 1ps

// Shared subtract/compare unit: x - y with borrow and zero detect.
module rru_sub #(
  parameter int DW = 32
) (
  input  logic [DW-1:0]      x,
  input  logic [DW-1:0]      y,
  output logic [DW-1:0]      diff,
  output rru_pkg::sub_flags_t flags
);

  logic [DW:0] full;

  assign full         = {1'b0, x} - {1'b0, y};
  assign diff         = full[DW-1:0];
  assign flags.borrow = full[DW];
  assign flags.zero   = (full[DW-1:0] == '0);

endmodule

### design/rru_reduce.sv
`timescale 1ns / 1ps

// Reduce a pair of nonzero magnitudes by their GCD.
// Binary GCD, then two restoring divisions, all on one subtractor.
module rru_reduce #(
  parameter int MW = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [MW-1:0] num_mag,
  input  logic [MW-1:0] den_mag,
  output logic          done,
  output logic [MW-1:0] q_num,
  output logic [MW-1:0] q_den
);

  localparam int KW = $clog2(MW + 1);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_GCD  = 2'd1;
  localparam logic [1:0] R_DIVN = 2'd2;
  localparam logic [1:0] R_DIVD = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [MW-1:0] a_r, a_nxt;
  logic [MW-1:0] b_r, b_nxt;
  logic [MW-1:0] g_r, g_nxt;
  logic [MW-1:0] dvd_r, dvd_nxt;
  logic [MW-1:0] den_r, den_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [MW-1:0] qn_r, qn_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;

  logic [MW:0]         sub_x;
  logic [MW:0]         sub_y;
  logic [MW:0]         sub_diff;
  rru_pkg::sub_flags_t sub_flags;
  logic [MW-1:0]       div_rem;
  logic [MW-1:0]       div_quo;
  logic                div_last;

  assign sub_x = (state_r == R_GCD) ? {1'b0, a_r} : {rem_r, dvd_r[MW-1]};
  assign sub_y = (state_r == R_GCD) ? {1'b0, b_r} : {1'b0, g_r};

  rru_sub #(.DW(MW + 1)) u_sub (
    .x     (sub_x),
    .y     (sub_y),
    .diff  (sub_diff),
    .flags (sub_flags)
  );

  // One restoring division step
  assign div_rem  = sub_flags.borrow ? sub_x[MW-1:0] : sub_diff[MW-1:0];
  assign div_quo  = {dvd_r[MW-2:0], ~sub_flags.borrow};
  assign div_last = (cnt_r == KW'(MW - 1));

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    g_nxt     = g_r;
    dvd_nxt   = dvd_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    qn_nxt    = qn_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          a_nxt     = num_mag;
          b_nxt     = den_mag;
          dvd_nxt   = num_mag;
          den_nxt   = den_mag;
          k_nxt     = '0;
          state_nxt = R_GCD;
        end
      end
      R_GCD: begin
        if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + KW'(1);
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (sub_flags.zero) begin
          // odd parts match: restore the common power of two
          g_nxt     = a_r << k_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = R_DIVN;
        end else if (sub_flags.borrow) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          a_nxt = sub_diff[MW:1];
        end
      end
      R_DIVN: begin
        rem_nxt = div_rem;
        dvd_nxt = div_quo;
        cnt_nxt = cnt_r + KW'(1);
        if (div_last) begin
          qn_nxt    = div_quo;
          dvd_nxt   = den_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = R_DIVD;
        end
      end
      R_DIVD: begin
        rem_nxt = div_rem;
        dvd_nxt = div_quo;
        cnt_nxt = cnt_r + KW'(1);
        if (div_last) begin
          done_nxt  = 1'b1;
          state_nxt = R_IDLE;
        end
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    g_r   <= g_nxt;
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    qn_r  <= qn_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done  = done_r;
  assign q_num = qn_r;
  assign q_den = dvd_r;

endmodule
